[rtl/vmey_pkg.sv]
// shared constants, types and the cordic arctangent table
`timescale 1ns / 1ps
package vmey_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int BASIS_FRAC_DEF = 14;
  localparam int ROUNDS = 28;
  localparam int QB = 30;
  localparam int FIFO_DEPTH = 4;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0: r = 34'sd536870912;
        1: r = 34'sd316933406;
        2: r = 34'sd167458907;
        3: r = 34'sd85004756;
        4: r = 34'sd42667331;
        5: r = 34'sd21354465;
        6: r = 34'sd10679838;
        7: r = 34'sd5340245;
        8: r = 34'sd2670163;
        9: r = 34'sd1335087;
        10: r = 34'sd667544;
        11: r = 34'sd333772;
        12: r = 34'sd166886;
        13: r = 34'sd83443;
        14: r = 34'sd41722;
        15: r = 34'sd20861;
        16: r = 34'sd10430;
        17: r = 34'sd5215;
        18: r = 34'sd2608;
        19: r = 34'sd1304;
        20: r = 34'sd652;
        21: r = 34'sd326;
        22: r = 34'sd163;
        23: r = 34'sd81;
        24: r = 34'sd41;
        25: r = 34'sd20;
        26: r = 34'sd10;
        27: r = 34'sd5;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // sine and cosine pair in q30, within [-1, 1]
  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sc_t;

  // front-end beat: position plus three sine/cosine pairs
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    sc_t ax;
    sc_t ay;
    sc_t az;
  } front_t;

  // q30 product rounded with ties up
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [63:0] p;
    begin
      p = a * b + 64'sd536870912;
      return 32'(p >>> QB);
    end
  endfunction
endpackage

[rtl/vmey_cordic.sv]
// pipelined cordic: an input register, then one rotation per stage, sine and cosine of one angle
`timescale 1ns / 1ps
module vmey_cordic import vmey_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic adv,
  input  logic [ANGLE_BITS-1:0] angle,
  output sc_t  sc
);
  logic signed [33:0] x [ROUNDS+1];
  logic signed [33:0] y [ROUNDS+1];
  logic signed [33:0] z [ROUNDS+1];
  logic flip [ROUNDS+1];
  logic [31:0] a0;
  logic [31:0] a1;
  logic signed [33:0] xc;
  logic signed [33:0] yc;

  always_comb begin
    a0 = {angle, {(32-ANGLE_BITS){1'b0}}};
    a1 = (a0[31] ^ a0[30]) ? a0 + 32'h8000_0000 : a0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x[0] <= GAIN_Q30;
      y[0] <= '0;
      z[0] <= 34'(signed'(a1));
      flip[0] <= a0[31] ^ a0[30];
    end
  end

  for (genvar i = 0; i < ROUNDS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv) begin
        flip[i+1] <= flip[i];
        if (!z[i][33]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_turn(i);
        end
      end
    end
  end

  always_comb begin
    xc = (x[ROUNDS] > ONE_Q30) ? ONE_Q30 : (x[ROUNDS] < -ONE_Q30) ? -ONE_Q30 : x[ROUNDS];
    yc = (y[ROUNDS] > ONE_Q30) ? ONE_Q30 : (y[ROUNDS] < -ONE_Q30) ? -ONE_Q30 : y[ROUNDS];
    sc.c = 32'(flip[ROUNDS] ? -xc : xc);
    sc.s = 32'(flip[ROUNDS] ? -yc : yc);
  end
endmodule

[rtl/vmey_front.sv]
// front end: takes input beats and forms sines and cosines in a pipeline
`timescale 1ns / 1ps
module vmey_front import vmey_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [ANGLE_BITS-1:0] angle_x,
  input  logic signed [ANGLE_BITS-1:0] angle_y,
  input  logic signed [ANGLE_BITS-1:0] angle_z,
  output logic out_valid,
  output front_t out_beat
);
  localparam int LAT = ROUNDS + 1;
  logic [LAT-1:0] vld;
  logic signed [31:0] px [LAT];
  logic signed [31:0] py [LAT];
  logic signed [31:0] pz [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px[0] <= pos_x;
      py[0] <= pos_y;
      pz[0] <= pos_z;
      for (int i = 1; i < LAT; i++) begin
        px[i] <= px[i-1];
        py[i] <= py[i-1];
        pz[i] <= pz[i-1];
      end
    end
  end

  vmey_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cx (.clk, .adv, .angle(angle_x), .sc(out_beat.ax));
  vmey_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cy (.clk, .adv, .angle(angle_y), .sc(out_beat.ay));
  vmey_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cz (.clk, .adv, .angle(angle_z), .sc(out_beat.az));

  assign out_valid = vld[LAT-1];
  assign out_beat.px = px[LAT-1];
  assign out_beat.py = py[LAT-1];
  assign out_beat.pz = pz[LAT-1];
endmodule

[rtl/vmey_fifo.sv]
// queue of beats, used between front and back and as the deep output queue
`timescale 1ns / 1ps
module vmey_fifo import vmey_pkg::*; #(
  parameter int W = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  logic [W-1:0] wdata,
  input  logic rd,
  output logic [W-1:0] rdata,
  output logic nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  // entries held in the memory, not counting the head register
  logic [CNTW-1:0] fill;
  logic hv;
  logic take;
  logic load;

  assign take = rd && hv;
  // head register refills from the memory whenever it is free or being taken
  assign load = (fill != '0) && (!hv || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
      hv <= 1'b0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (load) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      fill <= fill + CNTW'(wr) - CNTW'(load);
      if (load) hv <= 1'b1;
      else if (take) hv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (load) rdata <= mem[rp];
  end

  assign nonempty = hv;
  assign count = fill + CNTW'(hv);

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    !(wr && !load && fill == CNTW'(DEPTH)))
    else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst) !(rd && !hv))
    else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (rst)
    wr && !take |=> count == $past(count) + 1'b1)
    else $error("count did not grow");
`endif
endmodule

[rtl/vmey_back.sv]
// back end: basis products, rounding and translation, pipelined
`timescale 1ns / 1ps
module vmey_back import vmey_pkg::*; #(
  parameter int BASIS_FRAC_BITS = BASIS_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  front_t in_beat,
  output logic out_valid,
  output logic signed [BASIS_FRAC_BITS+1:0] m [9],
  output logic signed [31:0] t [3]
);
  localparam int BW = BASIS_FRAC_BITS + 2;
  localparam int SH = QB - BASIS_FRAC_BITS;
  localparam logic signed [33:0] BONE = 34'sd1 <<< BASIS_FRAC_BITS;
  localparam logic signed [33:0] HALF = 34'sd1 <<< (SH - 1);
  localparam logic signed [63:0] TH = 64'sd1 <<< (BASIS_FRAC_BITS - 1);

  logic [4:0] vld;
  // stage 1: pair products
  logic signed [31:0] c1c3, s1s2, c1s2, c3s1, c1s3, s1s3, c2s3, c2c3, c2s1, c1c2, ns2;
  logic signed [31:0] s3a, s2a;
  logic signed [31:0] p1 [3];
  // stage 2: q30 components
  logic signed [33:0] q [9];
  logic signed [31:0] p2 [3];
  // stage 3: rounded basis
  logic signed [BW-1:0] b3 [9];
  logic signed [31:0] p3 [3];
  // stage 4: products with position
  logic signed [BW+32-1:0] pr [9];
  logic signed [BW-1:0] b4 [9];
  logic signed [BW-1:0] b5 [9];
  logic signed [31:0] t5 [3];

  function automatic logic signed [BW-1:0] to_b(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + HALF) >>> SH;
      if (r > BONE) r = BONE;
      if (r < -BONE) r = -BONE;
      return BW'(r);
    end
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = (v + TH) >>> BASIS_FRAC_BITS;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return 32'(r);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[3:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1c3 <= mulq(in_beat.ay.c, in_beat.az.c);
      s1s2 <= mulq(in_beat.ay.s, in_beat.ax.s);
      c1s2 <= mulq(in_beat.ay.c, in_beat.ax.s);
      c3s1 <= mulq(in_beat.az.c, in_beat.ay.s);
      c1s3 <= mulq(in_beat.ay.c, in_beat.az.s);
      s1s3 <= mulq(in_beat.ay.s, in_beat.az.s);
      c2s3 <= mulq(in_beat.ax.c, in_beat.az.s);
      c2c3 <= mulq(in_beat.ax.c, in_beat.az.c);
      c2s1 <= mulq(in_beat.ax.c, in_beat.ay.s);
      c1c2 <= mulq(in_beat.ay.c, in_beat.ax.c);
      ns2 <= -in_beat.ax.s;
      s3a <= in_beat.az.s;
      s2a <= in_beat.ax.s;
      p1[0] <= in_beat.px;
      p1[1] <= in_beat.py;
      p1[2] <= in_beat.pz;

      q[0] <= 34'(c1c3) + 34'(mulq(s1s2, s3a));
      q[1] <= 34'(c2s3);
      q[2] <= 34'(mulq(c1s2, s3a)) - 34'(c3s1);
      q[3] <= 34'(mulq(c3s1, s2a)) - 34'(c1s3);
      q[4] <= 34'(c2c3);
      q[5] <= 34'(mulq(c1c3, s2a)) + 34'(s1s3);
      q[6] <= 34'(c2s1);
      q[7] <= 34'(ns2);
      q[8] <= 34'(c1c2);
      p2 <= p1;

      for (int i = 0; i < 9; i++) b3[i] <= to_b(q[i]);
      p3 <= p2;

      for (int i = 0; i < 9; i++) pr[i] <= b3[i] * p3[i % 3];
      b4 <= b3;

      for (int k = 0; k < 3; k++) begin
        t5[k] <= sat(-(64'(pr[3*k]) + 64'(pr[3*k+1]) + 64'(pr[3*k+2])));
      end
      b5 <= b4;
    end
  end

  assign out_valid = vld[4];
  assign m = b5;
  assign t = t5;
endmodule

[rtl/view_matrix_from_euler_yxz.sv]
// top level: yxz euler view matrix builder
// an accepted beat passes 38 register stages, the first at the accepting edge: 29 cordic,
//   2 mid queue, 5 back end and 2 in the output queue, then shows on the result ports
// throughput: one beat per cycle while full is low; full rises once 24 results wait,
//   leaving room for all in flight
// rst is synchronous and clears all valid bits and queue pointers; data is not reset
`timescale 1ns / 1ps
module view_matrix_from_euler_yxz import vmey_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int BASIS_FRAC_BITS = BASIS_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [ANGLE_BITS-1:0] angle_x,
  input  logic signed [ANGLE_BITS-1:0] angle_y,
  input  logic signed [ANGLE_BITS-1:0] angle_z,
  output logic empty,
  input  logic pop,
  output logic signed [BASIS_FRAC_BITS+1:0] right_x,
  output logic signed [BASIS_FRAC_BITS+1:0] right_y,
  output logic signed [BASIS_FRAC_BITS+1:0] right_z,
  output logic signed [BASIS_FRAC_BITS+1:0] upward_x,
  output logic signed [BASIS_FRAC_BITS+1:0] upward_y,
  output logic signed [BASIS_FRAC_BITS+1:0] upward_z,
  output logic signed [BASIS_FRAC_BITS+1:0] ahead_x,
  output logic signed [BASIS_FRAC_BITS+1:0] ahead_y,
  output logic signed [BASIS_FRAC_BITS+1:0] ahead_z,
  output logic signed [31:0] shift_x,
  output logic signed [31:0] shift_y,
  output logic signed [31:0] shift_z
);
  localparam int BW = BASIS_FRAC_BITS + 2;
  localparam int RW = 9 * BW + 96;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int OUT_DEPTH = 64;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  // the pipeline never stalls; beats drain into a deep output queue
  logic adv;
  logic fv;
  front_t fb;
  logic qv;
  logic [$bits(front_t)-1:0] qd;
  logic [CW-1:0] qcnt;
  logic bv;
  logic signed [BW-1:0] m [9];
  logic signed [31:0] t [3];
  logic [RW-1:0] rw;
  logic [RW-1:0] rr;
  logic onz;
  logic [OCW-1:0] ocnt;
  logic [OCW-1:0] inflight;

  // queued results plus 40, a bound for beats in front, mid queue and back stages
  assign inflight = OCW'(ocnt + 6'd40);
  assign adv = 1'b1;
  assign full = (inflight >= OCW'(OUT_DEPTH)) || rst;

  vmey_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk, .rst, .adv, .in_valid(push && !full),
    .pos_x, .pos_y, .pos_z, .angle_x, .angle_y, .angle_z,
    .out_valid(fv), .out_beat(fb)
  );

  vmey_fifo #(.W($bits(front_t)), .DEPTH(FIFO_DEPTH)) u_mid (
    .clk, .rst, .wr(fv), .wdata(fb), .rd(qv), .rdata(qd),
    .nonempty(qv), .count(qcnt)
  );

  vmey_back #(.BASIS_FRAC_BITS(BASIS_FRAC_BITS)) u_back (
    .clk, .rst, .adv, .in_valid(qv), .in_beat(front_t'(qd)),
    .out_valid(bv), .m, .t
  );

  assign rw = {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8], t[0], t[1], t[2]};

  vmey_fifo #(.W(RW), .DEPTH(OUT_DEPTH)) u_out (
    .clk, .rst, .wr(bv), .wdata(rw), .rd(pop && onz), .rdata(rr),
    .nonempty(onz), .count(ocnt)
  );

  assign empty = !onz;
  assign {right_x, right_y, right_z, upward_x, upward_y, upward_z,
          ahead_x, ahead_y, ahead_z, shift_x, shift_y, shift_z} = rr;

`ifndef ASSERT_OFF
  a_mid_shallow: assert property (@(posedge clk) disable iff (rst) qcnt <= CW'(2))
    else $error("mid queue backed up");
  a_room: assert property (@(posedge clk) disable iff (rst)
    bv |-> ocnt < OCW'(OUT_DEPTH) || pop)
    else $error("result beat with no room");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    empty |=> ocnt <= OCW'(2))
    else $error("empty queue count wrong");
`endif
endmodule

[dv/tb_view_matrix_from_euler_yxz.sv]
// testbench for the yxz euler view matrix builder: queue handshakes and a scoreboard
`timescale 1ns / 1ps
module tb_view_matrix_from_euler_yxz;
  import vmey_pkg::*;

  localparam int AB = ANGLE_BITS_DEF;
  localparam int FB = BASIS_FRAC_DEF;
  localparam int BW = FB + 2;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [AB-1:0] ax, ay, az;
  } pose_t;

  typedef struct {
    logic signed [BW-1:0] m [9];
    logic signed [31:0] t [3];
  } view_t;

  class view_board;
    view_t pending[$];
    int errors;

    static function longint fshift(longint x, int n);
      return x >>> n;
    endfunction

    static function longint rshift(longint x, int n);
      if (n == 0) return x;
      return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    static function longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    static function longint mq(longint a, longint b);
      return rshift(a * b, 30);
    endfunction

    static function void sincos(logic [AB-1:0] raw, output longint s, output longint c);
      logic [31:0] a;
      logic [1:0] quad;
      bit flip;
      longint x, y, z, nx, one;
      a = {raw, {(32 - AB){1'b0}}};
      quad = a[31:30];
      flip = quad == 2'd1 || quad == 2'd2;
      if (flip) a = a + 32'h8000_0000;
      z = longint'($signed(a));
      x = GAIN_Q30;
      y = 0;
      one = 64'sd1 <<< 30;
      for (int i = 0; i < ROUNDS; i++) begin
        if (z >= 0) begin
          nx = x - fshift(y, i);
          y = y + fshift(x, i);
          z -= longint'(atan_turn(i));
        end else begin
          nx = x + fshift(y, i);
          y = y - fshift(x, i);
          z += longint'(atan_turn(i));
        end
        x = nx;
      end
      x = clampv(x, -one, one);
      y = clampv(y, -one, one);
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_pose(pose_t p);
      longint c1, s1, c2, s2, c3, s3, one, tt;
      longint m [9];
      longint pv [3];
      view_t v;
      sincos(p.ax, s2, c2);
      sincos(p.ay, s1, c1);
      sincos(p.az, s3, c3);
      m[0] = mq(c1, c3) + mq(mq(s1, s2), s3);
      m[1] = mq(c2, s3);
      m[2] = mq(mq(c1, s2), s3) - mq(c3, s1);
      m[3] = mq(mq(c3, s1), s2) - mq(c1, s3);
      m[4] = mq(c2, c3);
      m[5] = mq(mq(c1, c3), s2) + mq(s1, s3);
      m[6] = mq(c2, s1);
      m[7] = -s2;
      m[8] = mq(c1, c2);
      one = 64'sd1 <<< FB;
      pv[0] = p.px; pv[1] = p.py; pv[2] = p.pz;
      for (int i = 0; i < 9; i++) begin
        m[i] = clampv(rshift(m[i], 30 - FB), -one, one);
        v.m[i] = m[i][BW-1:0];
      end
      for (int i = 0; i < 3; i++) begin
        tt = -(m[3*i] * pv[0] + m[3*i+1] * pv[1] + m[3*i+2] * pv[2]);
        v.t[i] = 32'(clampv(rshift(tt, FB), -64'sd2147483648, 64'sd2147483647));
      end
      pending.push_back(v);
    endfunction

    function void check_view(view_t got);
      view_t w;
      string mn [9] = '{"right_x", "right_y", "right_z", "upward_x", "upward_y",
                        "upward_z", "ahead_x", "ahead_y", "ahead_z"};
      string tn [3] = '{"shift_x", "shift_y", "shift_z"};
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      w = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.m[i] !== w.m[i]) begin
          $error("%s expected %0d got %0d", mn[i], w.m[i], got.m[i]);
          errors++;
        end
      for (int i = 0; i < 3; i++)
        if (got.t[i] !== w.t[i]) begin
          $error("%s expected %0d got %0d", tn[i], w.t[i], got.t[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0, rst = 1, push = 0, pop = 0;
  logic full, empty;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [AB-1:0] angle_x = 0, angle_y = 0, angle_z = 0;
  logic signed [BW-1:0] right_x, right_y, right_z, upward_x, upward_y, upward_z;
  logic signed [BW-1:0] ahead_x, ahead_y, ahead_z;
  logic signed [31:0] shift_x, shift_y, shift_z;

  view_board board = new();
  int send_idle = 27, take_idle = 70;
  bit sending_done = 0;

  always #1 clk = ~clk;

  view_matrix_from_euler_yxz dut (.*);

  // receiver: random stalls, checks each beat
  always @(posedge clk) begin
    view_t g;
    if (!rst && pop && !empty) begin
      g.m = '{right_x, right_y, right_z, upward_x, upward_y, upward_z,
              ahead_x, ahead_y, ahead_z};
      g.t = '{shift_x, shift_y, shift_z};
      board.check_view(g);
    end
    pop <= ($urandom_range(99) >= take_idle);
  end

  // push stays high between back-to-back beats and drops only while idling
  task automatic send_pose(pose_t p);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
    angle_x <= p.ax; angle_y <= p.ay; angle_z <= p.az;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_pose(p);
  endtask

  function automatic logic [AB-1:0] pick_angle();
    logic [AB-1:0] special [10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                                    16'h3FFF, 16'hBFFF, 16'hFFFF, 16'h0001, 16'h2000};
    if ($urandom_range(5) == 0)
      return AB'(special[$urandom_range(9)] + $urandom_range(2) - 1);
    return AB'($urandom());
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return $signed($urandom_range(20'hFFFFF)) - 32'sd524288;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    pose_t p;
    logic [AB-1:0] dir [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                               16'h3FFF, 16'hBFFF, 16'h2000};
    repeat (6) @(posedge clk);
    rst <= 0;
    // axis quadrant edges and large positions to drive translation saturation
    for (int i = 0; i < 8; i++) begin
      p.ax = dir[i]; p.ay = dir[(i + 3) % 8]; p.az = dir[(i + 5) % 8];
      p.px = 32'h7FFF_FFFF; p.py = 32'h7FFF_FFFF; p.pz = 32'h8000_0000;
      send_pose(p);
    end
    for (int i = 0; i < 8; i++) begin
      p.ax = dir[i]; p.ay = dir[i]; p.az = dir[i];
      p.px = i[0] ? 32'h8000_0000 : 0;
      p.py = i[1] ? 32'h8000_0000 : 32'hFFFF_FFFF;
      p.pz = i[2] ? 32'h7FFF_FFFF : 32'h0001_0000;
      send_pose(p);
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 27 : (ph == 1 ? 70 : 0);
      take_idle = ph == 0 ? 70 : (ph == 1 ? 27 : 0);
      for (int n = 0; n < 645; n++) begin
        p.ax = pick_angle(); p.ay = pick_angle(); p.az = pick_angle();
        p.px = pick_pos(); p.py = pick_pos(); p.pz = pick_pos();
        send_pose(p);
      end
    end
    push <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0 && !(!empty)) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
